// File: sv/multi_category_histogram_macros.svh
// Assertion helpers for the histogram block.
// Each macro expects clk and arst_n in scope of the user.
`ifndef MULTI_CATEGORY_HISTOGRAM_MACROS_SVH
`define MULTI_CATEGORY_HISTOGRAM_MACROS_SVH

// same-cycle implication
`define MCH_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("histogram assertion failed");

// next-cycle implication
`define MCH_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("histogram assertion failed");

`endif

// File: sv/mch_pkg.sv
// ----------------------------------------------------------------------------
// mch_pkg
// Shared constants, types and register codes of the multi-category histogram.
// ----------------------------------------------------------------------------
package mch_pkg;

	localparam int MAX_BINS       = 64;
	localparam int NUM_CATEGORIES = 32;
	localparam int COUNT_WIDTH    = 32;

	localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CAT_W = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
	// effective bin count never exceeds the 7-bit num_bins register
	localparam int NB_W  = 7;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE = 2'd2;

	localparam logic [NB_W-1:0] NUM_BINS_RST  = 7'd50;
	localparam logic [31:0]     MIN_VALUE_RST = 32'd0;
	localparam logic [31:0]     BIN_SCALE_RST = 32'd65536;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_ADDR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             clr;
		logic             inc;
		logic [BIN_W-1:0] addr;
	} lane_ctl_t;

	typedef struct packed {
		logic [NB_W-1:0] bin;
		logic            clamped;
	} bin_res_t;

endpackage

// File: sv/multi_category_histogram.sv
// ----------------------------------------------------------------------------
// multi_category_histogram
// 32 category histograms binned from Q16.16 samples, one bank lane per
// category, with a read mux merging the lanes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command per transaction:
//   cmd=0 bins sample_value and bumps that bin in each category set in
//   category_mask; cmd=1 returns the counter at read_category/read_bin.
//   Output channel (out_valid/out_stall) returns one transaction per command.
//   One command is in flight at a time: a new command is accepted only once
//   the previous one has passed the offset, multiply, counter read and
//   write-back steps through the bank memories. The output register lets a
//   new command enter while a result waits; a finished command holds in its
//   last step while out_stall keeps the previous result. Reset and every
//   write to a used register index (cfg_we) run a clearing sweep over all 64
//   bin rows, one bin row of all lanes per cycle; in_stall is high meanwhile.
//   Write registers only while the block is idle.
// ----------------------------------------------------------------------------
`include "multi_category_histogram_macros.svh"

module multi_category_histogram (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mch_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic signed [31:0]             sample_value,
	input  logic [31:0]                    category_mask,
	input  logic [4:0]                     read_category,
	input  logic [5:0]                     read_bin,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [31:0]                    read_count,
	output logic [5:0]                     bin_index,
	output logic                           bin_clamped
);
	import mch_pkg::*;

	state_t state_q, state_nxt;

	logic [NB_W-1:0]  num_bins_q;
	logic [31:0]      min_value_q;
	logic [31:0]      bin_scale_q;
	logic             cfg_hit;
	logic [BIN_W-1:0] clr_q;

	logic             cmd_q;
	logic [31:0]      mask_q;
	logic [4:0]       rd_cat_q;
	logic [5:0]       rd_bin_q;

	logic             accept;
	logic             out_load;
	lane_ctl_t        lane_ctl;
	bin_res_t         bres;

	logic [COUNT_WIDTH-1:0] lane_count [NUM_CATEGORIES];
	logic [COUNT_WIDTH-1:0] sel_count;
	logic                   rd_in_range;
	logic [31:0]            rd_value;

	logic             out_valid_q;
	logic [31:0]      read_count_q;
	logic [5:0]       bin_index_q;
	logic             bin_clamped_q;

	// ---------------- configuration ----------------
	always_comb begin
		case (cfg_index)
			REG_NUM_BINS:  cfg_hit = cfg_we;
			REG_MIN_VALUE: cfg_hit = cfg_we;
			REG_BIN_SCALE: cfg_hit = cfg_we;
			default:       cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q  <= NUM_BINS_RST;
			min_value_q <= MIN_VALUE_RST;
			bin_scale_q <= BIN_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_BINS:  num_bins_q  <= cfg_data[NB_W-1:0];
				REG_MIN_VALUE: min_value_q <= cfg_data;
				REG_BIN_SCALE: bin_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- control ----------------
	assign accept = in_valid && !in_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == BIN_W'(MAX_BINS - 1)) state_nxt = S_IDLE;
			S_IDLE:  if (in_valid) state_nxt = S_MUL;
			S_MUL:   state_nxt = S_ADDR;
			S_ADDR:  state_nxt = S_DONE;
			S_DONE:  if (!out_valid_q || !out_stall) state_nxt = S_IDLE;
			default: state_nxt = S_CLEAR;
		endcase
		// a write to any used register index restarts the clearing sweep
		if (cfg_hit) begin
			state_nxt = S_CLEAR;
		end
	end

	always_comb begin
		in_stall     = 1'b1;
		out_load     = 1'b0;
		lane_ctl.clr = 1'b0;
		lane_ctl.inc = 1'b0;
		lane_ctl.addr = BIN_W'(bres.bin);
		case (state_q)
			S_CLEAR: begin
				lane_ctl.clr  = 1'b1;
				lane_ctl.addr = clr_q;
			end
			S_IDLE: begin
				in_stall = 1'b0;
			end
			S_MUL: ;
			S_ADDR: begin
				if (cmd_q == CMD_READ) begin
					lane_ctl.addr = BIN_W'(rd_bin_q);
				end
			end
			S_DONE: begin
				// hold the read address while the result waits
				if (cmd_q == CMD_READ) begin
					lane_ctl.addr = BIN_W'(rd_bin_q);
				end
				out_load     = !out_valid_q || !out_stall;
				lane_ctl.inc = out_load && (cmd_q == CMD_ADD);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_hit) begin
				clr_q <= '0;
			end else if (state_q == S_CLEAR) begin
				clr_q <= clr_q + BIN_W'(1);
			end
		end
	end

	// hold the command fields for the transaction in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			mask_q   <= category_mask;
			rd_cat_q <= read_category;
			rd_bin_q <= read_bin;
		end
	end

	// ---------------- datapath ----------------
	mch_binner u_binner (
		.clk          (clk),
		.load         (accept),
		.sample_value (sample_value),
		.min_value    (min_value_q),
		.bin_scale    (bin_scale_q),
		.num_bins     (num_bins_q),
		.res          (bres)
	);

	for (genvar c = 0; c < NUM_CATEGORIES; c++) begin : g_lane
		mch_lane u_lane (
			.clk   (clk),
			.ctl   (lane_ctl),
			.en    (mask_q[c]),
			.count (lane_count[c])
		);
	end

	// merge: pick the addressed category
	assign rd_in_range = (6'(rd_cat_q) < 6'(NUM_CATEGORIES)) &&
		(32'(rd_bin_q) < 32'(MAX_BINS));
	assign sel_count = lane_count[rd_cat_q[CAT_W-1:0]];

	always_comb begin
		rd_value = 32'(sel_count);
		if ((64'(sel_count) >> 32) != 64'd0) begin
			rd_value = '1;
		end
		if (!rd_in_range) begin
			rd_value = '0;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (cmd_q == CMD_READ) begin
				read_count_q  <= rd_value;
				bin_index_q   <= '0;
				bin_clamped_q <= 1'b0;
			end else begin
				read_count_q  <= '0;
				bin_index_q   <= 6'(bres.bin);
				bin_clamped_q <= bres.clamped;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign read_count  = read_count_q;
	assign bin_index   = bin_index_q;
	assign bin_clamped = bin_clamped_q;

	// ---------------- assertions ----------------
	`MCH_ASSERT_NXT(a_accept_to_mul, accept && !cfg_hit, state_q == S_MUL)
	`MCH_ASSERT_IMP(a_no_inc_in_clear, state_q == S_CLEAR, !lane_ctl.inc)
	`MCH_ASSERT_NXT(a_done_delivers, out_load && !cfg_hit, out_valid && state_q == S_IDLE)
	`MCH_ASSERT_IMP(a_stall_outside_idle, state_q != S_IDLE, in_stall)

endmodule

// File: sv/mch_binner.sv
// ----------------------------------------------------------------------------
// mch_binner
// Two-stage bin computation: offset from the lower edge, then multiply by the
// configured scale and clamp the integer part to the active bin range.
// ----------------------------------------------------------------------------
module mch_binner (
	input  logic                    clk,
	input  logic                    load,
	input  logic signed [31:0]      sample_value,
	input  logic signed [31:0]      min_value,
	input  logic [31:0]             bin_scale,
	input  logic [mch_pkg::NB_W-1:0] num_bins,
	output mch_pkg::bin_res_t       res
);
	import mch_pkg::*;

	logic signed [32:0] diff_s1;
	logic               neg_s2;
	logic [63:0]        prod_s2;
	logic [NB_W-1:0]    nb;
	logic [31:0]        prod_hi;
	logic               over;

	// capture the offset with the accepted transaction
	always_ff @(posedge clk) begin
		if (load) begin
			diff_s1 <= {sample_value[31], sample_value} - {min_value[31], min_value};
		end
	end

	always_ff @(posedge clk) begin
		neg_s2  <= diff_s1[32];
		prod_s2 <= 64'(diff_s1[31:0]) * 64'(bin_scale);
	end

	always_comb begin
		nb = num_bins;
		if (num_bins == '0) begin
			nb = NB_W'(1);
		end else if (32'(num_bins) > 32'(MAX_BINS)) begin
			nb = NB_W'(MAX_BINS);
		end
	end

	assign prod_hi = prod_s2[63:32];
	assign over    = prod_hi >= 32'(nb);

	always_comb begin
		if (neg_s2) begin
			res.bin     = '0;
			res.clamped = bin_scale != '0;
		end else if (over) begin
			res.bin     = nb - NB_W'(1);
			res.clamped = 1'b1;
		end else begin
			res.bin     = prod_hi[NB_W-1:0];
			res.clamped = 1'b0;
		end
	end

endmodule

// File: sv/mch_lane.sv
// ----------------------------------------------------------------------------
// mch_lane
// One category bank: counter memory with registered read and a saturating
// increment write-back.
// ----------------------------------------------------------------------------
module mch_lane (
	input  logic                           clk,
	input  mch_pkg::lane_ctl_t             ctl,
	input  logic                           en,
	output logic [mch_pkg::COUNT_WIDTH-1:0] count
);
	import mch_pkg::*;

	logic [COUNT_WIDTH-1:0] mem [MAX_BINS];
	logic [COUNT_WIDTH-1:0] rdata_q;
	logic [COUNT_WIDTH-1:0] wdata;
	logic                   we;

	assign we    = ctl.clr || (ctl.inc && en);
	// hold at full scale
	assign wdata = ctl.clr ? '0 :
		((rdata_q == '1) ? rdata_q : rdata_q + COUNT_WIDTH'(1));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[ctl.addr] <= wdata;
		end
		rdata_q <= mem[ctl.addr];
	end

	assign count = rdata_q;

endmodule

// File: verif/tb_multi_category_histogram.sv
// ----------------------------------------------------------------------------
// tb_multi_category_histogram
// Self-checking bench for the 32-category histogram. A directed script covers
// reset contents, range edges, clamping, zero scale, out-of-range bin counts
// and the unused register index; random phases then reconfigure the block and
// mix adds and reads under random input gaps and output stalls. Each result is
// compared against the script's expected values or a bench-side model of the counter banks.
// ----------------------------------------------------------------------------
module tb_multi_category_histogram;
	import mch_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] count;
		logic [5:0]  bin;
		logic        clamped;
	} hist_result_t;

	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [31:0]          data;
		logic                 c;
		logic [31:0]          s;
		logic [31:0]          m;
		logic [4:0]           rc;
		logic [5:0]           rb;
		logic                 chk;
		hist_result_t         want;
	} step_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [31:0]           cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  cmd;
	logic signed [31:0]    sample_value;
	logic [31:0]           category_mask;
	logic [4:0]            read_category;
	logic [5:0]            read_bin;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [31:0]           read_count;
	logic [5:0]            bin_index;
	logic                  bin_clamped;

	// bench copy of the configuration and counter banks
	logic [NB_W-1:0]        nb_reg;
	logic signed [31:0]     floor_reg;
	logic [31:0]            scale_reg;
	logic [COUNT_WIDTH-1:0] counts [NUM_CATEGORIES][MAX_BINS];

	hist_result_t pending_q[$];
	step_row_t    script[$];
	bit           failed;
	bit           quiet;
	int           last_bin;

	multi_category_histogram u_top (.*);

	always #10 clk = ~clk;

	function automatic void clear_counts();
		foreach (counts[c, b])
			counts[c][b] = '0;
	endfunction

	// bin one add transaction into the bench banks, or look up a read
	function automatic hist_result_t bin_sample(logic c, logic signed [31:0] s,
			logic [31:0] m, logic [4:0] rc, logic [5:0] rb);
		hist_result_t r;
		longint       diff;
		logic [63:0]  prod;
		logic [31:0]  hi;
		int           nb;
		int           k;
		r = '0;
		if (c == CMD_ADD) begin
			nb = int'(nb_reg);
			if (nb < 1)
				nb = 1;
			if (nb > MAX_BINS)
				nb = MAX_BINS;
			diff = longint'(s) - longint'(floor_reg);
			if (diff < 0) begin
				hi = '0;
				r.clamped = (scale_reg != '0);
			end else begin
				prod = 64'(diff) * {32'd0, scale_reg};
				hi = prod[63:32];
				if (hi >= 32'(nb)) begin
					hi = 32'(nb - 1);
					r.clamped = 1'b1;
				end
			end
			r.bin = hi[5:0];
			last_bin = int'(hi);
			for (k = 0; k < NUM_CATEGORIES; k++)
				if (m[k] && counts[k][hi[BIN_W-1:0]] != '1)
					counts[k][hi[BIN_W-1:0]]++;
		end else begin
			r.count = counts[rc][rb];
		end
		return r;
	endfunction

	function automatic step_row_t row_add(logic [31:0] s, logic [31:0] m, bit chk,
			int b, bit cl);
		step_row_t r;
		r = '0;
		r.c = CMD_ADD;
		r.s = s;
		r.m = m;
		r.rc = 5'($urandom);
		r.rb = 6'($urandom);
		r.chk = chk;
		r.want.bin = 6'(b);
		r.want.clamped = cl;
		return r;
	endfunction

	function automatic step_row_t row_read(int rc, int rb, bit chk, logic [31:0] n);
		step_row_t r;
		r = '0;
		r.c = CMD_READ;
		r.s = $urandom;
		r.m = $urandom;
		r.rc = 5'(rc);
		r.rb = 6'(rb);
		r.chk = chk;
		r.want.count = n;
		return r;
	endfunction

	function automatic step_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		step_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = d;
		return r;
	endfunction

	// present one transaction, hold it until accepted, then record its result
	task automatic send_txn(logic c, logic signed [31:0] s, logic [31:0] m,
			logic [4:0] rc, logic [5:0] rb, bit chk, hist_result_t want);
		int           gap;
		hist_result_t pred;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		sample_value <= s;
		category_mask <= m;
		read_category <= rc;
		read_bin <= rb;
		do @(posedge clk); while (in_stall);
		pred = bin_sample(c, s, m, rc, rb);
		pending_q.push_back(chk ? want : pred);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_NUM_BINS:  nb_reg = data[NB_W-1:0];
			REG_MIN_VALUE: floor_reg = data;
			REG_BIN_SCALE: scale_reg = data;
			default:       return;
		endcase
		clear_counts();
	endtask

	// output side: random stall, then take the next transaction and compare
	initial begin : result_check
		int           n;
		hist_result_t want;
		forever begin
			n = quiet ? 0 : $urandom_range(0, 4);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got count=%h bin=%0d clamped=%b",
					$time, read_count, bin_index, bin_clamped);
				failed = 1'b1;
			end else begin
				want = pending_q.pop_front();
				if (read_count !== want.count) begin
					$display("%0t: read_count expected %h got %h", $time, want.count, read_count);
					failed = 1'b1;
				end
				if (bin_index !== want.bin) begin
					$display("%0t: bin_index expected %0d got %0d", $time, want.bin, bin_index);
					failed = 1'b1;
				end
				if (bin_clamped !== want.clamped) begin
					$display("%0t: bin_clamped expected %b got %b", $time, want.clamped,
						bin_clamped);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin : stimulus
		logic [CFG_IDX_W-1:0] reg_order [3];
		logic [31:0]          reg_val [3];
		int                   nb;
		int                   nb_eff;
		int                   span;
		int                   lo;
		int                   kind;
		int                   sel;
		logic [31:0]          m;
		logic signed [31:0]   s;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_ADD;
		sample_value = '0;
		category_mask = '0;
		read_category = '0;
		read_bin = '0;
		failed = 1'b0;
		quiet = 1'b0;
		last_bin = 0;
		nb_reg = NUM_BINS_RST;
		floor_reg = MIN_VALUE_RST;
		scale_reg = BIN_SCALE_RST;
		clear_counts();
		reg_order = '{REG_NUM_BINS, REG_MIN_VALUE, REG_BIN_SCALE};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset setup: 50 bins of one unit each starting at zero
		script = '{
			row_read(0, 0, 1, 0),
			row_add(32'h0000_0000, 32'hFFFF_FFFF, 1, 0, 0),
			row_add(32'h0003_8000, 32'h0000_0001, 1, 3, 0),
			row_add(32'h7FFF_FFFF, 32'h8000_0000, 1, 49, 1),
			row_add(32'h8000_0000, 32'hFFFF_FFFF, 1, 0, 1),
			row_add(32'h0031_FFFF, 32'h0000_0001, 1, 49, 0),
			row_add(32'h0032_0000, 32'h0000_0002, 1, 49, 1),
			row_add(32'hFFFF_FFFF, 32'h0000_0000, 1, 0, 1),
			row_read(0, 0, 1, 2),
			row_read(31, 49, 1, 1),
			row_read(31, 63, 1, 0),
			// unused index leaves the banks alone
			row_cfg(REG_UNUSED, 32'hFFFF_FFFF),
			row_read(0, 0, 1, 2),
			// zero scale lands everything in bin 0, never clamped
			row_cfg(REG_BIN_SCALE, 32'h0000_0000),
			row_add(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0),
			row_add(32'h8000_0000, 32'h0000_0001, 1, 0, 0),
			row_read(0, 0, 1, 2),
			// zero bin count behaves as a single bin
			row_cfg(REG_NUM_BINS, 32'hFFFF_FF80),
			row_read(5, 0, 1, 0),
			row_cfg(REG_BIN_SCALE, 32'hFFFF_FFFF),
			row_add(32'h7FFF_FFFF, 32'h0000_0005, 1, 0, 1),
			row_add(32'h0000_0000, 32'h0000_0001, 1, 0, 0),
			// oversized bin count caps at the full bank
			row_cfg(REG_NUM_BINS, 32'd127),
			row_read(2, 0, 1, 0),
			row_cfg(REG_MIN_VALUE, 32'h8000_0000),
			row_read(0, 63, 1, 0),
			row_cfg(REG_BIN_SCALE, 32'h0040_0000),
			row_add(32'h8000_FC00, 32'hFFFF_FFFF, 1, 63, 0),
			row_add(32'h7FFF_FFFF, 32'h8000_0000, 1, 63, 1),
			row_read(31, 63, 1, 2),
			row_read(0, 63, 1, 1),
			row_cfg(REG_MIN_VALUE, 32'h7FFF_FFFF),
			row_add(32'h8000_0000, 32'h0000_0001, 1, 0, 1),
			row_add(32'h7FFF_FFFF, 32'h0000_0001, 1, 0, 0),
			row_read(0, 0, 1, 2)
		};
		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				drain_results();
				write_reg(script[i].idx, script[i].data);
			end else begin
				send_txn(script[i].c, script[i].s, script[i].m, script[i].rc, script[i].rb,
					script[i].chk, script[i].want);
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0:       nb = 1;
				1:       nb = 64;
				2:       nb = 127;
				3:       nb = 0;
				default: nb = $urandom_range(2, 63);
			endcase
			nb_eff = (nb < 1) ? 1 : (nb > MAX_BINS) ? MAX_BINS : nb;
			span = $urandom_range(1, 200);
			lo = (int'($urandom_range(0, 2000)) - 1000) * 65536 + int'($urandom_range(0, 65535));
			reg_val[0] = nb;
			reg_val[1] = lo;
			case (ph)
				4:       reg_val[2] = 32'h0000_0000;
				5:       reg_val[2] = 32'hFFFF_FFFF;
				default: reg_val[2] = (nb_eff * 65536) / span;
			endcase
			// reconfigure from idle; a read between writes lets each clear finish
			for (int r = 0; r < 3; r++) begin
				drain_results();
				write_reg(reg_order[r], reg_val[r]);
				send_txn(CMD_READ, $urandom, $urandom, 5'($urandom), 6'($urandom), 0, '0);
			end
			for (int j = 0; j < 132; j++) begin
				if (j % 40 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				kind = $urandom_range(0, 99);
				sel = $urandom_range(0, 9);
				case (sel)
					0:       m = '0;
					1:       m = '1;
					2:       m = 32'd1 << $urandom_range(0, 31);
					default: m = $urandom;
				endcase
				if (kind < 62) begin
					s = lo + int'($urandom_range(0, (span + 4) * 65536)) - 2 * 65536;
					send_txn(CMD_ADD, s, m, 5'($urandom), 6'($urandom), 0, '0);
				end else if (kind < 72) begin
					send_txn(CMD_ADD, $urandom, m, 5'($urandom), 6'($urandom), 0, '0);
				end else if (kind < 75) begin
					s = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					send_txn(CMD_ADD, s, m, 5'($urandom), 6'($urandom), 0, '0);
				end else begin
					send_txn(CMD_READ, $urandom, $urandom, 5'($urandom),
						$urandom_range(0, 1) ? 6'(last_bin) : 6'($urandom_range(0, 63)),
						0, '0);
				end
			end
			quiet = 1'b0;
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (!failed)
			$display("multi_category_histogram verification clean");
		else
			$display("multi_category_histogram verification failed");
		$finish;
	end

	initial begin : watchdog
		#8000000;
		$display("multi_category_histogram verification failed");
		$finish;
	end

endmodule
